@@ rtl/billiard_motion_advance_assert.svh @@
// assertion macros for the billiard motion advance block
// included by the top level only
`ifndef BILLIARD_MOTION_ADVANCE_ASSERT_SVH
`define BILLIARD_MOTION_ADVANCE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define BMA_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define BMA_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ rtl/bma_pkg.sv @@
// shared types and constants for the billiard motion advance block
// used by bma_divider, bma_mover, the top level and the testbench
package bma_pkg;
    localparam int MaxLegs = 64;
    localparam int FracBits = 16;
    localparam int LegW = $clog2(MaxLegs + 1);
    localparam int TimeW = 48;
    localparam int TqW = 33 + FracBits + 1;
    localparam int DivW = 32 + FracBits;

    localparam logic [2:0] REG_AREA_W = 3'd0;
    localparam logic [2:0] REG_AREA_H = 3'd1;
    localparam logic [2:0] REG_START_X = 3'd2;
    localparam logic [2:0] REG_START_Y = 3'd3;
    localparam logic [2:0] REG_VEL_X = 3'd4;
    localparam logic [2:0] REG_VEL_Y = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LEG, ST_DIVX, ST_WAITX, ST_DIVY, ST_WAITY,
        ST_MULX, ST_MULY, ST_UPDATE, ST_DONE
    } state_t;

    // saturating negation of a signed 32-bit word
    function automatic logic [31:0] neg_sat(input logic [31:0] v);
        logic [31:0] r;
        r = (v == 32'h8000_0000) ? 32'h7FFF_FFFF : (~v + 32'd1);
        return r;
    endfunction
endpackage

@@ rtl/bma_divider.sv @@
// shared restoring divider, one quotient bit per cycle, ceiling result
// depends on bma_pkg
module bma_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bma_pkg::DivW-1:0]      dividend,
    input  logic [31:0]                   divisor,
    output logic                          busy,
    output logic                          done,
    output logic [bma_pkg::DivW-1:0]      quotient
);
    localparam int CntW = $clog2(bma_pkg::DivW + 1);
    logic [bma_pkg::DivW-1:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    // one restoring step, then round up on a nonzero remainder
    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted = {r_reg[31:0], q_reg[bma_pkg::DivW-1]};
        trial = shifted - {1'b0, d_reg};
        if (start) begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = CntW'(bma_pkg::DivW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                if (r_reg != '0) q_next = q_reg + 1'b1;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                if (!trial[32]) begin
                    r_next = trial;
                    q_next = {q_reg[bma_pkg::DivW-2:0], 1'b1};
                end else begin
                    r_next = shifted;
                    q_next = {q_reg[bma_pkg::DivW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = q_reg;
endmodule

@@ rtl/bma_mover.sv @@
// one-axis displacement and clamp, registered after the multiplies
// depends on bma_pkg
module bma_mover (
    input  logic                     aclk,
    input  logic                     load,
    input  logic [31:0]              pos,
    input  logic [31:0]              vel,
    input  logic [bma_pkg::TqW-1:0]  t,
    input  logic [31:0]              lim,
    output logic [31:0]              new_pos
);
    localparam int F = bma_pkg::FracBits;
    logic [31:0] av;
    logic [63:0] p_hi_reg, p_lo_reg;
    logic        big_reg, neg_reg, zero_reg;
    logic [31:0] pos_reg, lim_reg;
    logic [64:0] disp;
    logic [35:0] disp_s;
    logic signed [37:0] np;
    logic [bma_pkg::TqW-F-1:0] hi;

    assign av = vel[31] ? (~vel + 32'd1) : vel;
    assign hi = t[bma_pkg::TqW-1:F];

    // two 32x32 products registered
    always_ff @(posedge aclk) begin
        if (load) begin
            p_hi_reg <= av * hi[31:0];
            p_lo_reg <= av * {{(32-F){1'b0}}, t[F-1:0]};
            big_reg <= |hi[bma_pkg::TqW-F-1:32];
            neg_reg <= vel[31];
            zero_reg <= (av == '0);
            pos_reg <= pos;
            lim_reg <= lim;
        end
    end

    // saturate, add, clamp
    always_comb begin
        disp = {1'b0, p_hi_reg} + {{(F+1){1'b0}}, p_lo_reg[63:F]};
        if (zero_reg) disp_s = '0;
        else if (big_reg || disp > 65'(64'h4_0000_0000)) disp_s = 36'h4_0000_0000;
        else disp_s = disp[35:0];
        if (neg_reg) np = $signed({6'd0, pos_reg}) - $signed({2'd0, disp_s});
        else np = $signed({6'd0, pos_reg}) + $signed({2'd0, disp_s});
        if (np > $signed({6'd0, lim_reg})) new_pos = lim_reg;
        else if (np < 0) new_pos = '0;
        else new_pos = np[31:0];
    end
endmodule

@@ rtl/billiard_motion_advance.sv @@
// Billiard motion advance: moves a point bouncing in a rectangle to a target time.
// An advance request runs legs on one shared bit-serial ceiling divider: each leg has a
// setup state, a division for each wall that lies ahead (up to two divisions) and then the
// multiply and update states, with at most 64 legs per item. A restart goes straight to
// the result, and an advance whose target is not ahead ends after the setup state. The
// input is not ready until the result has been taken.
// Depends on bma_pkg, bma_divider, bma_mover and the assertion header.
`include "billiard_motion_advance_assert.svh"
module billiard_motion_advance (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // target_time[47:0]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [119:0] m_tdata,  // pos_x, pos_y, time_now, reflections
    output logic        m_tuser,   // capped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int F = bma_pkg::FracBits;
    localparam int TQ = bma_pkg::TqW;

    bma_pkg::state_t state_reg, state_next;
    logic [31:0] aw_reg, ah_reg, sx_reg, sy_reg, svx_reg, svy_reg;
    logic [31:0] cx_reg, cy_reg, vx_reg, vy_reg;
    logic [47:0] lt_reg, tgt_reg;
    logic [TQ-1:0] best_reg;
    logic at_end_reg;
    logic [bma_pkg::LegW-1:0] legs_reg;
    logic [6:0] refl_reg;
    logic capped_reg;
    logic out_valid_reg;

    logic div_start, div_busy, div_done;
    logic [bma_pkg::DivW-1:0] dividend, quot;
    logic [31:0] divisor;
    logic [31:0] nx, ny;
    logic [47:0] rem;
    logic x_ahead, y_ahead;
    logic [31:0] dist_x, dist_y, avx, avy;
    logic mover_load;

    assign s_tready = (state_reg == bma_pkg::ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {1'b0, refl_reg, lt_reg, cy_reg, cx_reg};
    assign m_tuser = capped_reg;

    // wall distances on each axis, divider operands and control strobes
    always_comb begin
        avx = vx_reg[31] ? (~vx_reg + 32'd1) : vx_reg;
        avy = vy_reg[31] ? (~vy_reg + 32'd1) : vy_reg;
        dist_x = vx_reg[31] ? cx_reg : aw_reg - cx_reg;
        dist_y = vy_reg[31] ? cy_reg : ah_reg - cy_reg;
        x_ahead = (vx_reg != '0) && (vx_reg[31] ? (cx_reg != '0) : (aw_reg > cx_reg));
        y_ahead = (vy_reg != '0) && (vy_reg[31] ? (cy_reg != '0) : (ah_reg > cy_reg));
        rem = tgt_reg - lt_reg;
        dividend = (state_reg == bma_pkg::ST_DIVX) ? {dist_x, {F{1'b0}}}
                                                    : {dist_y, {F{1'b0}}};
        divisor = (state_reg == bma_pkg::ST_DIVX) ? avx : avy;
        div_start = (state_reg == bma_pkg::ST_DIVX) || (state_reg == bma_pkg::ST_DIVY);
        mover_load = (state_reg == bma_pkg::ST_MULX);
    end

    bma_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(dividend),
        .divisor(divisor), .busy(div_busy), .done(div_done), .quotient(quot)
    );

    bma_mover u_mx (
        .aclk(aclk), .load(mover_load), .pos(cx_reg), .vel(vx_reg),
        .t(best_reg), .lim(aw_reg), .new_pos(nx)
    );
    bma_mover u_my (
        .aclk(aclk), .load(mover_load), .pos(cy_reg), .vel(vy_reg),
        .t(best_reg), .lim(ah_reg), .new_pos(ny)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bma_pkg::ST_IDLE:
                if (s_tvalid && s_tready) state_next = s_tuser ? bma_pkg::ST_DONE
                                                               : bma_pkg::ST_LEG;
            bma_pkg::ST_LEG:
                if (lt_reg >= tgt_reg) state_next = bma_pkg::ST_DONE;
                else if (legs_reg >= bma_pkg::LegW'(bma_pkg::MaxLegs))
                    state_next = bma_pkg::ST_DONE;
                else if (x_ahead) state_next = bma_pkg::ST_DIVX;
                else if (y_ahead) state_next = bma_pkg::ST_DIVY;
                else state_next = bma_pkg::ST_MULX;
            bma_pkg::ST_DIVX: state_next = bma_pkg::ST_WAITX;
            bma_pkg::ST_WAITX:
                if (div_done) state_next = y_ahead ? bma_pkg::ST_DIVY : bma_pkg::ST_MULX;
            bma_pkg::ST_DIVY: state_next = bma_pkg::ST_WAITY;
            bma_pkg::ST_WAITY: if (div_done) state_next = bma_pkg::ST_MULX;
            bma_pkg::ST_MULX: state_next = bma_pkg::ST_MULY;
            bma_pkg::ST_MULY: state_next = bma_pkg::ST_UPDATE;
            bma_pkg::ST_UPDATE:
                state_next = at_end_reg ? bma_pkg::ST_DONE : bma_pkg::ST_LEG;
            bma_pkg::ST_DONE: state_next = bma_pkg::ST_IDLE;
            default: state_next = bma_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= bma_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    // config registers, datapath and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aw_reg <= 32'd6553600;
            ah_reg <= 32'd6553600;
            sx_reg <= '0;
            sy_reg <= '0;
            svx_reg <= 32'd65536;
            svy_reg <= 32'd65536;
            cx_reg <= '0;
            cy_reg <= '0;
            vx_reg <= 32'd65536;
            vy_reg <= 32'd65536;
            lt_reg <= '0;
            out_valid_reg <= 1'b0;
            legs_reg <= '0;
            refl_reg <= '0;
            capped_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    bma_pkg::REG_AREA_W: aw_reg <= cfg_data;
                    bma_pkg::REG_AREA_H: ah_reg <= cfg_data;
                    bma_pkg::REG_START_X: sx_reg <= cfg_data;
                    bma_pkg::REG_START_Y: sy_reg <= cfg_data;
                    bma_pkg::REG_VEL_X: svx_reg <= cfg_data;
                    bma_pkg::REG_VEL_Y: svy_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                bma_pkg::ST_IDLE:
                    if (s_tvalid && s_tready) begin
                        tgt_reg <= s_tdata;
                        legs_reg <= '0;
                        refl_reg <= '0;
                        capped_reg <= 1'b0;
                        if (s_tuser) begin
                            cx_reg <= sx_reg;
                            cy_reg <= sy_reg;
                            vx_reg <= svx_reg;
                            vy_reg <= svy_reg;
                            lt_reg <= '0;
                        end
                    end
                bma_pkg::ST_LEG: begin
                    if (lt_reg < tgt_reg && legs_reg >= bma_pkg::LegW'(bma_pkg::MaxLegs))
                        capped_reg <= 1'b1;
                    legs_reg <= legs_reg + 1'b1;
                    at_end_reg <= 1'b1;
                    if (rem[47:33] != '0) best_reg <= TQ'(1) << (33 + F);
                    else best_reg <= TQ'({rem[32:0], {F{1'b0}}});
                end
                bma_pkg::ST_WAITX, bma_pkg::ST_WAITY:
                    if (div_done && TQ'(quot) < best_reg) begin
                        best_reg <= TQ'(quot);
                        at_end_reg <= 1'b0;
                    end
                bma_pkg::ST_UPDATE: begin
                    cx_reg <= nx;
                    cy_reg <= ny;
                    if (at_end_reg) lt_reg <= tgt_reg;
                    else begin
                        lt_reg <= lt_reg + 48'(best_reg[TQ-1:F]);
                        if ((!vx_reg[31] && vx_reg != '0 && nx == aw_reg) ||
                            (vx_reg[31] && nx == '0))
                            vx_reg <= bma_pkg::neg_sat(vx_reg);
                        else vy_reg <= bma_pkg::neg_sat(vy_reg);
                        if (refl_reg != 7'h7F) refl_reg <= refl_reg + 1'b1;
                    end
                end
                bma_pkg::ST_DONE: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    `BMA_ASSERT_IMP(a_no_accept_busy, aclk, aresetn,
        state_reg != bma_pkg::ST_IDLE, !s_tready)
    `BMA_ASSERT_NEXT(a_done_valid, aclk, aresetn,
        state_reg == bma_pkg::ST_DONE, m_tvalid)
    `BMA_ASSERT_IMP(a_div_only_wait, aclk, aresetn,
        div_busy, state_reg == bma_pkg::ST_WAITX || state_reg == bma_pkg::ST_WAITY)
endmodule

@@ verif/tb_top.sv @@
// testbench for billiard_motion_advance: bouncing point stepped to target times
// depends on bma_pkg and the billiard_motion_advance rtl; a scoreboard class predicts results
`timescale 1ns / 100ps

module tb_top;
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_RESTART = 1'b1;
    localparam longint unsigned DISP_LIMIT = 64'd1 << 34;
    localparam longint unsigned FRAC_MASK = (64'd1 << bma_pkg::FracBits) - 1;

    typedef struct {
        bit [31:0] pos_x;
        bit [31:0] pos_y;
        bit [47:0] time_now;
        bit [6:0]  reflections;
        bit        capped;
    } motion_result_t;

    // predicts the point motion and holds pending results
    class bounce_scoreboard;
        bit [31:0] area_w = 32'd6553600, area_h = 32'd6553600;
        bit [31:0] start_x = 0, start_y = 0;
        bit [31:0] init_vx = 32'd65536, init_vy = 32'd65536;
        bit [31:0] cur_x, cur_y, vel_x, vel_y;
        bit [47:0] now;
        motion_result_t pending[$];
        int errors = 0;
        int checked = 0;
        int bounces = 0;
        int capped_items = 0;

        function new();
            reload();
        endfunction

        function void reload();
            cur_x = start_x;
            cur_y = start_y;
            vel_x = init_vx;
            vel_y = init_vy;
            now = 0;
        endfunction

        function void write_reg(logic [2:0] idx, bit [31:0] d);
            case (idx)
                bma_pkg::REG_AREA_W: area_w = d;
                bma_pkg::REG_AREA_H: area_h = d;
                bma_pkg::REG_START_X: start_x = d;
                bma_pkg::REG_START_Y: start_y = d;
                bma_pkg::REG_VEL_X: init_vx = d;
                bma_pkg::REG_VEL_Y: init_vy = d;
                default: ;
            endcase
        endfunction

        function bit [31:0] flip_vel(bit [31:0] v);
            return (v == 32'h8000_0000) ? 32'h7FFF_FFFF : -v;
        endfunction

        // ticks (with fraction bits) until the wall ahead on one axis
        function bit wall_ahead(bit [31:0] pos, bit [31:0] lim, longint v,
                                output longint unsigned t);
            longint unsigned span, av;
            t = 0;
            if (v == 0) return 0;
            if (v > 0) begin
                if (lim <= pos) return 0;
                span = 64'(lim - pos);
                av = v;
            end else begin
                span = 64'(pos);
                av = -v;
            end
            if (span == 0) return 0;
            t = ((span << bma_pkg::FracBits) + av - 1) / av;
            return 1;
        endfunction

        function bit [31:0] slide(bit [31:0] pos, longint v, longint unsigned t,
                                  bit [31:0] lim);
            longint unsigned av, hi, lo, disp;
            longint np;
            av = (v < 0) ? -v : v;
            hi = t >> bma_pkg::FracBits;
            lo = t & FRAC_MASK;
            if (av == 0) disp = 0;
            else if (hi >= (64'd1 << 32)) disp = DISP_LIMIT;
            else disp = av * hi + ((av * lo) >> bma_pkg::FracBits);
            if (disp > DISP_LIMIT) disp = DISP_LIMIT;
            np = (v < 0) ? longint'(pos) - longint'(disp) : longint'(pos) + longint'(disp);
            if (np > longint'(lim)) np = lim;
            if (np < 0) np = 0;
            return np[31:0];
        endfunction

        // accepted request: restart or advance the model and queue its result
        function void note_request(logic op, bit [47:0] target);
            motion_result_t r;
            int legs, refl;
            longint vx, vy;
            longint unsigned rem, best, t;
            bit at_end;
            legs = 0;
            refl = 0;
            r.capped = 0;
            if (op == OP_RESTART) reload();
            else begin
                while (now < target) begin
                    if (legs >= bma_pkg::MaxLegs) begin
                        r.capped = 1;
                        break;
                    end
                    legs++;
                    at_end = 1;
                    vx = longint'(signed'(vel_x));
                    vy = longint'(signed'(vel_y));
                    rem = 64'(target) - 64'(now);
                    best = (rem >= (64'd1 << 33)) ? (64'd1 << (33 + bma_pkg::FracBits))
                                                  : (rem << bma_pkg::FracBits);
                    if (wall_ahead(cur_x, area_w, vx, t) && t < best) begin
                        best = t;
                        at_end = 0;
                    end
                    if (wall_ahead(cur_y, area_h, vy, t) && t < best) begin
                        best = t;
                        at_end = 0;
                    end
                    cur_x = slide(cur_x, vx, best, area_w);
                    cur_y = slide(cur_y, vy, best, area_h);
                    if (at_end) begin
                        now = target;
                        break;
                    end
                    now = 48'(64'(now) + (best >> bma_pkg::FracBits));
                    if ((vx > 0 && cur_x == area_w) || (vx < 0 && cur_x == 0))
                        vel_x = flip_vel(vel_x);
                    else
                        vel_y = flip_vel(vel_y);
                    if (refl < 127) refl++;
                end
            end
            r.pos_x = cur_x;
            r.pos_y = cur_y;
            r.time_now = now;
            r.reflections = refl[6:0];
            bounces += refl;
            capped_items += r.capped;
            pending.push_back(r);
        endfunction

        function void check_result(bit [119:0] d, bit cap);
            motion_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h/%b", $time, d, cap);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (d[31:0] !== e.pos_x) begin
                $display("%0t: pos_x expected %h actual %h", $time, e.pos_x, d[31:0]);
                errors++;
            end
            if (d[63:32] !== e.pos_y) begin
                $display("%0t: pos_y expected %h actual %h", $time, e.pos_y, d[63:32]);
                errors++;
            end
            if (d[111:64] !== e.time_now) begin
                $display("%0t: time_now expected %h actual %h", $time, e.time_now, d[111:64]);
                errors++;
            end
            if (d[118:112] !== e.reflections) begin
                $display("%0t: reflections expected %0d actual %0d", $time,
                         e.reflections, d[118:112]);
                errors++;
            end
            if (cap !== e.capped) begin
                $display("%0t: capped expected %b actual %b", $time, e.capped, cap);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;  // target_time[47:0]
    logic         s_tuser = 0;   // op
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [119:0] m_tdata;       // pos_x, pos_y, time_now, reflections, pad bit 119
    logic         m_tuser;       // capped
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    bounce_scoreboard sb = new();
    int burst_left = 4;
    bit hold_req = 0;
    int sent = 0;

    billiard_motion_advance DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 0;
                repeat (400) @(negedge aclk);
                hold_req = 0;
            end
            if ($urandom_range(0, 99) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: m_tready <= 1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_request(logic op, bit [47:0] target);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= target;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, target);
        sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, bit [31:0] d);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, d);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic set_all(bit [31:0] aw, bit [31:0] ah, bit [31:0] sx, bit [31:0] sy,
                           bit [31:0] vx, bit [31:0] vy);
        drain();
        write_reg(bma_pkg::REG_AREA_W, aw);
        write_reg(bma_pkg::REG_AREA_H, ah);
        write_reg(bma_pkg::REG_START_X, sx);
        write_reg(bma_pkg::REG_START_Y, sy);
        write_reg(bma_pkg::REG_VEL_X, vx);
        write_reg(bma_pkg::REG_VEL_Y, vy);
        send_request(OP_RESTART, 48'($urandom()));
    endtask

    function automatic bit [31:0] rand_vel();
        bit [31:0] m;
        m = $urandom_range(1 << 12, 1 << 19);
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    // random mix: mostly short advances, some stale targets, restarts, rare huge jumps
    task automatic random_items(int n);
        int k, sel;
        bit [47:0] tgt;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) send_request(OP_RESTART, {$urandom(), 16'($urandom())});
            else if (sel < 6) send_request(OP_ADVANCE, {16'($urandom()), $urandom()});
            else if (sel < 12) begin
                tgt = sb.now - $urandom_range(0, 5);
                send_request(OP_ADVANCE, (tgt > sb.now) ? sb.now : tgt);
            end else begin
                tgt = sb.now + $urandom_range(1, 20);
                send_request(OP_ADVANCE, (tgt < sb.now) ? 48'hFFFF_FFFF_FFFF : tgt);
            end
        end
    endtask

    // run limit
    initial begin
        #200ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int p;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // defaults: restart, stale targets, bounces, leg cap
        send_request(OP_RESTART, 48'hFFFF_FFFF_FFFF);
        send_request(OP_ADVANCE, 48'd0);
        send_request(OP_ADVANCE, 48'd50);
        send_request(OP_ADVANCE, 48'd50);
        send_request(OP_ADVANCE, 48'd49);
        send_request(OP_ADVANCE, 48'd250);
        send_request(OP_ADVANCE, 48'hFFFF_FFFF_FFFF);
        send_request(OP_RESTART, 48'd0);

        // most negative velocity, widest and empty areas
        set_all(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(OP_ADVANCE, 48'd3);
        send_request(OP_ADVANCE, 48'd10);
        send_request(OP_ADVANCE, 48'h0001_0000_0000);

        // start outside the rectangle
        set_all(32'd10 << 16, 32'd20 << 16, 32'd50 << 16, 32'hFFFF_FFFF,
                32'hFFFF_0000, 32'h0002_0000);
        send_request(OP_ADVANCE, 48'd1);
        send_request(OP_ADVANCE, 48'd30);

        // zero velocity: targets over the full range
        set_all(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd7 << 16, 32'd0, 32'd0);
        send_request(OP_ADVANCE, 48'hFFFF_FFFF_FFFF);
        send_request(OP_RESTART, 48'd0);
        random_items(40);
        for (p = 0; p < 20; p++) send_request(OP_ADVANCE, {16'($urandom()), $urandom()});

        // long hold-off on the result side while requests keep coming
        set_all(32'd100 << 16, 32'd100 << 16, 32'd3 << 16, 32'd90 << 16,
                rand_vel(), rand_vel());
        hold_req = 1;
        random_items(60);

        // random settings
        for (p = 0; p < 6; p++) begin
            set_all($urandom_range(10, 200) << 16, $urandom_range(10, 200) << 16,
                    $urandom_range(0, 220) << 16, $urandom_range(0, 220) << 16,
                    rand_vel(), rand_vel());
            random_items(100);
        end

        drain();
        $display("%0d requests sent, %0d results checked, %0d reflections, %0d capped",
                 sent, sb.checked, sb.bounces, sb.capped_items);
        $display("covered restarts, stale targets, saturation cases and random settings");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
